// ----- sv/ssort_pkg.sv -----
// Shared constants and types for the streaming insertion sorter.
// No dependencies; used by ssort_cell and streaming_insertion_sorter_core.
`default_nettype none

package ssort_pkg;

    localparam int WORD_W           = 32;
    localparam int DEFAULT_CAPACITY = 64;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- sv/streaming_insertion_sorter_core.sv -----
// Top level of the streaming insertion sorter: control and the chain of cells.
// Depends on ssort_pkg and ssort_cell.
//
// Usage:
//   Input: present i_value and i_final_item with start high; the word is taken
//   at a rising edge where start is high and busy is low. One word per cycle
//   is taken while a set is being collected; each is placed into its sorted
//   position in the same cycle by a row of CAPACITY compare cells.
//   Output: after the word marked i_final_item is taken, busy rises and the
//   set is emitted in ascending order, one word per cycle on o_sorted_value
//   with o_strobe high, starting in the cycle right after that edge. While
//   a set drains, the chain shifts toward cell 0 once per cycle. o_end_of_set
//   marks the last word, o_overflowed marks every word of a set in which
//   words beyond CAPACITY were dropped.
//   The receiver cannot stall: each word is shown for exactly one cycle.
//   Reset (synchronous, active low) empties the chain and clears busy.
`default_nettype none

module streaming_insertion_sorter_core #(
    parameter int CAPACITY = ssort_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [ssort_pkg::WORD_W-1:0] i_value,
    input  wire logic                                i_final_item,
    output logic                                     o_strobe,
    output logic signed [ssort_pkg::WORD_W-1:0]      o_sorted_value,
    output logic                                     o_end_of_set,
    output logic                                     o_overflowed
);

    logic                                r_emit;
    logic                                n_emit;
    logic                                r_overflow;
    logic                                n_overflow;
    logic                                accept;
    logic                                full;
    ssort_pkg::t_cell_ctl                ctl;

    logic                                cell_valid   [CAPACITY];
    logic signed [ssort_pkg::WORD_W-1:0] cell_value   [CAPACITY];
    logic                                cell_greater [CAPACITY];

    assign accept        = start && !r_emit;
    assign full          = cell_valid[CAPACITY-1];
    assign ctl.insert    = accept && !full;
    assign ctl.shift_out = r_emit;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                                prev_valid;
            logic signed [ssort_pkg::WORD_W-1:0] prev_value;
            logic                                prev_greater;
            logic                                next_valid;
            logic signed [ssort_pkg::WORD_W-1:0] next_value;

            if (g == 0) begin : g_head
                assign prev_valid   = 1'b1;
                assign prev_value   = i_value;
                assign prev_greater = 1'b0;
            end else begin : g_body
                assign prev_valid   = cell_valid[g-1];
                assign prev_value   = cell_value[g-1];
                assign prev_greater = cell_greater[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign next_valid = 1'b0;
                assign next_value = cell_value[g];
            end else begin : g_mid
                assign next_valid = cell_valid[g+1];
                assign next_value = cell_value[g+1];
            end

            ssort_cell u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctl          (ctl),
                .i_new_value    (i_value),
                .i_prev_valid   (prev_valid),
                .i_prev_value   (prev_value),
                .i_prev_greater (prev_greater),
                .i_next_valid   (next_valid),
                .i_next_value   (next_value),
                .o_valid        (cell_valid[g]),
                .o_value        (cell_value[g]),
                .o_greater      (cell_greater[g])
            );
        end
    endgenerate

    always_comb begin
        n_emit     = r_emit;
        n_overflow = r_overflow;
        if (r_emit) begin
            if (!cell_valid[1]) begin
                n_emit     = 1'b0;
                n_overflow = 1'b0;
            end
        end else if (accept) begin
            if (full) begin
                n_overflow = 1'b1;
            end
            if (i_final_item) begin
                n_emit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit     <= 1'b0;
            r_overflow <= 1'b0;
        end else begin
            r_emit     <= n_emit;
            r_overflow <= n_overflow;
        end
    end

    assign busy           = r_emit;
    assign o_strobe       = r_emit;
    assign o_sorted_value = cell_value[0];
    assign o_end_of_set   = r_emit && !cell_valid[1];
    assign o_overflowed   = r_emit && r_overflow;

endmodule

`default_nettype wire

// ----- sv/ssort_cell.sv -----
// One compare-and-hold cell of the sorting chain.
// Depends on ssort_pkg for the word width and the control struct.
`default_nettype none

module ssort_cell (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire ssort_pkg::t_cell_ctl                i_ctl,
    input  wire logic signed [ssort_pkg::WORD_W-1:0] i_new_value,
    input  wire logic                                i_prev_valid,
    input  wire logic signed [ssort_pkg::WORD_W-1:0] i_prev_value,
    input  wire logic                                i_prev_greater,
    input  wire logic                                i_next_valid,
    input  wire logic signed [ssort_pkg::WORD_W-1:0] i_next_value,
    output logic                                     o_valid,
    output logic signed [ssort_pkg::WORD_W-1:0]      o_value,
    output logic                                     o_greater
);

    logic                                r_valid;
    logic                                n_valid;
    logic signed [ssort_pkg::WORD_W-1:0] r_value;
    logic signed [ssort_pkg::WORD_W-1:0] n_value;

    assign o_greater = r_valid && (r_value > i_new_value);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctl.shift_out) begin
            n_valid = i_next_valid;
            n_value = i_next_value;
        end else if (i_ctl.insert) begin
            if (i_prev_greater) begin
                n_valid = 1'b1;
                n_value = i_prev_value;
            end else if (o_greater) begin
                n_value = i_new_value;
            end else if (!r_valid && i_prev_valid) begin
                n_valid = 1'b1;
                n_value = i_new_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

`default_nettype wire

// ----- test/sorted_stream_checker.sv -----
// Checker for streaming_insertion_sorter_core: predicts each sorted set and compares the
// output words field by field. It keeps its own sorted store.
// Depends on ssort_pkg; instantiated by tb_streaming_insertion_sorter_core.
module sorted_stream_checker #(
    parameter int CAPACITY = ssort_pkg::DEFAULT_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic signed [ssort_pkg::WORD_W-1:0] i_value,
    input  logic                                i_final_item,
    input  logic                                o_strobe,
    input  logic signed [ssort_pkg::WORD_W-1:0] o_sorted_value,
    input  logic                                o_end_of_set,
    input  logic                                o_overflowed,
    output int                                  fail_count,
    output int                                  pending_words,
    output int                                  words_checked,
    output int                                  sets_checked,
    output int                                  overflow_sets
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [ssort_pkg::WORD_W-1:0] word_t;

    typedef struct {
        word_t word;
        logic  last;
        logic  ovf;
    } sorted_word_t;

    word_t        held_words[CAPACITY];
    int           held_count;
    logic         dropped_any;
    sorted_word_t due_words[$];
    int           errors_seen;
    int           checked_total;
    int           sets_total;
    int           ovf_total;

    initial begin
        held_count    = 0;
        dropped_any   = 1'b0;
        errors_seen   = 0;
        checked_total = 0;
        sets_total    = 0;
        ovf_total     = 0;
        fail_count    = 0;
        pending_words = 0;
        words_checked = 0;
        sets_checked  = 0;
        overflow_sets = 0;
    end

    // insert after any equal words already held; drop when full
    function automatic void insert_word(input word_t w);
        int slot;
        int k;
        if (held_count >= CAPACITY) begin
            dropped_any = 1'b1;
            return;
        end
        slot = 0;
        while (slot < held_count && held_words[slot] <= w)
            slot++;
        for (k = held_count; k > slot; k--)
            held_words[k] = held_words[k - 1];
        held_words[slot] = w;
        held_count++;
    endfunction

    function automatic void append_due(input sorted_word_t entry);
        due_words = {due_words, entry};
    endfunction

    function automatic void release_sorted_set();
        int k;
        for (k = 0; k < held_count; k++)
            append_due('{word: held_words[k], last: (k == held_count - 1),
                         ovf: dropped_any});
        held_count  = 0;
        dropped_any = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        sorted_word_t due;
        if (!i_rst_n) begin
            due_words.delete();
            held_count  = 0;
            dropped_any = 1'b0;
        end else begin
            if (o_strobe !== 1'b0) begin
                if (due_words.size() == 0) begin
                    $error("unexpected word: o_sorted_value=%0d o_end_of_set=%b o_overflowed=%b",
                           o_sorted_value, o_end_of_set, o_overflowed);
                    errors_seen++;
                end else begin
                    due = due_words.pop_front();
                    if (o_sorted_value !== due.word) begin
                        $error("sorted_value: expected %0d, actual %0d",
                               due.word, o_sorted_value);
                        errors_seen++;
                    end
                    if (o_end_of_set !== due.last) begin
                        $error("end_of_set: expected %b, actual %b", due.last, o_end_of_set);
                        errors_seen++;
                    end
                    if (o_overflowed !== due.ovf) begin
                        $error("overflowed: expected %b, actual %b", due.ovf, o_overflowed);
                        errors_seen++;
                    end
                    checked_total++;
                    if (due.last) begin
                        sets_total++;
                        if (due.ovf)
                            ovf_total++;
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                insert_word(i_value);
                if (i_final_item)
                    release_sorted_set();
            end
        end
        fail_count    <= errors_seen;
        pending_words <= due_words.size();
        words_checked <= checked_total;
        sets_checked  <= sets_total;
        overflow_sets <= ovf_total;
    end

endmodule

// ----- test/tb_streaming_insertion_sorter_core.sv -----
// Testbench top for streaming_insertion_sorter_core: drives directed and random sets
// with random gaps and reports the verdict. Depends on ssort_pkg, the core and
// sorted_stream_checker.
module tb_streaming_insertion_sorter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = ssort_pkg::DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT = 200000;
    localparam int WORD_TARGET = 260;

    typedef logic signed [ssort_pkg::WORD_W-1:0] word_t;

    localparam word_t WORD_MIN = 32'sh8000_0000;
    localparam word_t WORD_MAX = 32'sh7fff_ffff;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    word_t i_value;
    logic  i_final_item;
    logic  o_strobe;
    word_t o_sorted_value;
    logic  o_end_of_set;
    logic  o_overflowed;

    int fail_count;
    int pending_words;
    int words_checked;
    int sets_checked;
    int overflow_sets;
    int words_sent;
    int cycle_count = 0;

    streaming_insertion_sorter_core #(.CAPACITY(CAPACITY)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_final_item  (i_final_item),
        .o_strobe      (o_strobe),
        .o_sorted_value(o_sorted_value),
        .o_end_of_set  (o_end_of_set),
        .o_overflowed  (o_overflowed)
    );

    sorted_stream_checker #(.CAPACITY(CAPACITY)) u_sort_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_final_item  (i_final_item),
        .o_strobe      (o_strobe),
        .o_sorted_value(o_sorted_value),
        .o_end_of_set  (o_end_of_set),
        .o_overflowed  (o_overflowed),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .words_checked (words_checked),
        .sets_checked  (sets_checked),
        .overflow_sets (overflow_sets)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic word_t rand_value();
        case ($urandom_range(0, 9))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2, 3, 4: return word_t'($urandom_range(0, 16)) - 8;
            default: return word_t'($urandom);
        endcase
    endfunction

    // hold start high across back-to-back words; lower it only for a gap
    task automatic send_word(input word_t w, input logic fin, input logic burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_value      <= w;
        i_final_item <= fin;
        do @(posedge i_clk); while (busy);
        words_sent++;
    endtask

    task automatic send_list(input word_t words[$]);
        int k;
        for (k = 0; k < words.size(); k++)
            send_word(words[k], k == words.size() - 1, 1'b0);
    endtask

    task automatic send_random_set(input int count);
        logic burst;
        int   k;
        burst = ($urandom_range(0, 3) == 0);
        for (k = 0; k < count; k++)
            send_word(rand_value(), k == count - 1, burst);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
    endtask

    initial begin
        word_t seq[$];
        words_sent   = 0;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_value      <= '0;
        i_final_item <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-word sets at both extremes
        seq = '{WORD_MIN};
        send_list(seq);
        seq = '{WORD_MAX};
        send_list(seq);
        // extremes, signs and duplicates mixed
        seq = '{0, -1, 1, WORD_MAX, WORD_MIN, -1, 5, 5, 0};
        send_list(seq);
        seq = '{-2, -2, -2};
        send_list(seq);
        seq = '{3, 2, 1, 0, -1, -2};
        send_list(seq);

        while (words_sent < 90)
            send_random_set($urandom_range(1, 8));
        // fill the store exactly, then overflow it with the final word dropped
        send_random_set(CAPACITY);
        wait_drained();
        send_random_set(CAPACITY + 1 + $urandom_range(0, 3));
        while (words_sent < WORD_TARGET) begin
            send_random_set($urandom_range(1, 8));
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (CAPACITY + 8) @(posedge i_clk);

        $display("Sent %0d words in %0d sets (%0d overflowed); checked %0d sorted words.",
                 words_sent, sets_checked, overflow_sets, words_checked);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/ssort_pkg.sv
sv/ssort_cell.sv
sv/streaming_insertion_sorter_core.sv
test/sorted_stream_checker.sv
test/tb_streaming_insertion_sorter_core.sv
